FILE: hdl/llac_pkg.sv
package llac_pkg;

  // field widths
  localparam int SampleW   = 10;
  localparam int TimeW     = 32;
  localparam int IntervalW = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  // packed stream widths
  localparam int InDataW   = 48;
  localparam int OutDataW  = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DARK_CRIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DARK_ATT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_ATT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_CRIT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL   = 3'd4;

  // register reset values
  localparam logic [SampleW-1:0]   DARK_CRIT_RST  = 10'd450;
  localparam logic [SampleW-1:0]   DARK_ATT_RST   = 10'd600;
  localparam logic [SampleW-1:0]   LIGHT_ATT_RST  = 10'd800;
  localparam logic [SampleW-1:0]   LIGHT_CRIT_RST = 10'd950;
  localparam logic [IntervalW-1:0] INTERVAL_RST   = 16'd3000;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_ATTENTION = 2'd1,
    ST_CRITICAL  = 2'd2
  } llac_status_t;

  // threshold set handed to the classifier
  typedef struct packed {
    logic [SampleW-1:0] dark_crit;
    logic [SampleW-1:0] dark_att;
    logic [SampleW-1:0] light_att;
    logic [SampleW-1:0] light_crit;
  } llac_thresh_t;

  // classifier verdict
  typedef struct packed {
    llac_status_t status;
    logic         lamp_on;
  } llac_class_t;

endpackage

FILE: hdl/llac_cell.sv
module llac_cell (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic [llac_pkg::SampleW-1:0] sample_in,
  output logic [llac_pkg::SampleW-1:0] sample_out
);
  import llac_pkg::*;

  logic [SampleW-1:0] sample_r;

  // one window slot: takes the neighbor's sample on every accepted request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= sample_in;
    end
  end

  assign sample_out = sample_r;

endmodule

FILE: hdl/llac_classify.sv
module llac_classify (
  input  logic [llac_pkg::SampleW-1:0] level,
  input  llac_pkg::llac_thresh_t       thresh,
  output llac_pkg::llac_class_t        verdict
);
  import llac_pkg::*;

  // fixed-priority band check, first match wins
  always_comb begin
    if (level < thresh.dark_crit) begin
      verdict.status = ST_CRITICAL;
    end else if (level < thresh.dark_att) begin
      verdict.status = ST_ATTENTION;
    end else if (level <= thresh.light_att) begin
      verdict.status = ST_NORMAL;
    end else if (level <= thresh.light_crit) begin
      verdict.status = ST_ATTENTION;
    end else begin
      verdict.status = ST_CRITICAL;
    end
    verdict.lamp_on = (level < thresh.dark_att);
  end

endmodule

FILE: hdl/light_level_average_classifier_core.sv
// Moving-average light classifier. Samples shift through a chain of WINDOW
// cells; the cell at the end of the chain holds the oldest sample, which is
// subtracted from the running total as the new one is added. The first WINDOW
// requests only fill the chain and give no result; each later request gives
// one result (total update, then reciprocal-multiply average, band
// classification and report check). One request is taken per cycle; a result
// waiting at the output stalls the chain only once the middle stage is also
// full. The user must write threshold and interval registers through the cfg
// port only while no request is in flight; the block does not enforce this.
module light_level_average_classifier_core #(
  parameter int WINDOW = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: light_sample[9:0], now_ms[41:10], zero pad [47:42]
  input  logic [llac_pkg::InDataW-1:0]  in_tdata,
  // in_tuser: force_report[0]
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: average_level[9:0], light_status[11:10], lamp_on[12],
  //            status_changed[13], report_request[14], zero pad [15]
  output logic [llac_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_wr_en,
  input  logic [llac_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [llac_pkg::CfgDataW-1:0] cfg_wdata
);
  import llac_pkg::*;

  localparam int WinL   = $clog2(WINDOW);
  localparam int TotW   = SampleW + WinL;
  localparam int CntW   = $clog2(WINDOW + 1);
  localparam int Shift  = TotW + WinL;
  localparam int RecipW = Shift + 1;
  localparam int ProdW  = TotW + RecipW;
  // ceil(2^Shift / WINDOW): exact floor quotient for every total below 2^TotW
  localparam int RecipInt = ((1 << Shift) + WINDOW - 1) / WINDOW;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipInt);
  localparam logic [CntW-1:0]   WinCnt = CntW'(WINDOW);

  // configuration registers
  llac_thresh_t         thresh_r;
  logic [IntervalW-1:0] interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.dark_crit  <= DARK_CRIT_RST;
      thresh_r.dark_att   <= DARK_ATT_RST;
      thresh_r.light_att  <= LIGHT_ATT_RST;
      thresh_r.light_crit <= LIGHT_CRIT_RST;
      interval_r          <= INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DARK_CRIT:  thresh_r.dark_crit  <= cfg_wdata[SampleW-1:0];
        CFG_DARK_ATT:   thresh_r.dark_att   <= cfg_wdata[SampleW-1:0];
        CFG_LIGHT_ATT:  thresh_r.light_att  <= cfg_wdata[SampleW-1:0];
        CFG_LIGHT_CRIT: thresh_r.light_crit <= cfg_wdata[SampleW-1:0];
        CFG_INTERVAL:   interval_r          <= cfg_wdata[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // handshake and flow control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r;
  logic out_move, s1_move, in_acc;

  assign out_move  = !out_valid_r || out_tready;
  assign s1_move   = !s1_valid_r || out_move;
  assign in_tready = s1_move;
  assign in_acc    = in_tvalid && in_tready;

  // input fields
  logic [SampleW-1:0] in_sample;
  logic [TimeW-1:0]   in_now;
  assign in_sample = in_tdata[SampleW-1:0];
  assign in_now    = in_tdata[SampleW +: TimeW];

  // sample chain
  logic [SampleW-1:0] tap [WINDOW+1];
  assign tap[0] = in_sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    llac_cell u_cell (
      .clk        (clk),
      .shift_en   (in_acc),
      .sample_in  (tap[i]),
      .sample_out (tap[i+1])
    );
  end

  // priming count and running total
  logic [CntW-1:0] prime_cnt_r, prime_cnt_nxt;
  logic [TotW-1:0] total_r, total_nxt;
  logic            primed;

  assign primed = (prime_cnt_r == WinCnt);

  always_comb begin
    prime_cnt_nxt = prime_cnt_r;
    total_nxt     = total_r;
    s1_valid_nxt  = s1_valid_r;
    if (s1_move) begin
      s1_valid_nxt = in_acc && primed;
    end
    if (in_acc) begin
      if (primed) begin
        total_nxt = total_r + TotW'(in_sample) - TotW'(tap[WINDOW]);
      end else begin
        total_nxt     = total_r + TotW'(in_sample);
        prime_cnt_nxt = prime_cnt_r + CntW'(1);
      end
    end
  end

  // stage 1 context of the request
  logic [TimeW-1:0] s1_now_r;
  logic             s1_force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_cnt_r <= '0;
      total_r     <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      prime_cnt_r <= prime_cnt_nxt;
      total_r     <= total_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r   <= in_now;
      s1_force_r <= in_tuser;
    end
  end

  // stage 2: average by reciprocal multiply
  logic [ProdW-1:0]   prod;
  logic [SampleW-1:0] avg;
  assign prod = ProdW'(total_r) * ProdW'(Recip);
  assign avg  = prod[Shift +: SampleW];

  llac_class_t verdict;
  llac_classify u_classify (
    .level   (avg),
    .thresh  (thresh_r),
    .verdict (verdict)
  );

  // status change and report check
  llac_status_t     last_status_r;
  logic [TimeW-1:0] last_report_ms_r;
  logic [TimeW-1:0] elapsed;
  logic             due, changed, report;
  logic             s2_fire;

  assign s2_fire = s1_valid_r && out_move;
  assign elapsed = s1_now_r - last_report_ms_r;
  assign due     = (elapsed >= TimeW'(interval_r));
  assign changed = (verdict.status != last_status_r);
  assign report  = due || changed || s1_force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_status_r    <= ST_NORMAL;
      last_report_ms_r <= '0;
    end else if (s2_fire) begin
      last_status_r <= verdict.status;
      if (due) begin
        last_report_ms_r <= s1_now_r;
      end
    end
  end

  // output register
  logic [OutDataW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_data_r <= {1'b0, report, changed, verdict.lamp_on, verdict.status, avg};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_no_result_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> primed)
    else $error("result pending before window filled");

  a_change_reports: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[14])
    else $error("status change without report request");

  a_lamp_not_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11:10] != ST_NORMAL)
    else $error("lamp on while status normal");

  a_report_time: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && due |=> last_report_ms_r == $past(s1_now_r))
    else $error("report timestamp not updated");

endmodule
